// ----- rtl/bpfa_pkg.sv -----
// Shared types and constants of the bitmap page frame allocator.
package bpfa_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC_ONE = 2'd0,
        OP_ALLOC_RUN = 2'd1,
        OP_FREE_RUN  = 2'd2,
        OP_LOCK_RUN  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_RANGE      = 2'd2,
        ST_ZERO_COUNT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_EVAL,
        S_BIT,
        S_FILL_RD,
        S_FILL_WR,
        S_DONE
    } state_t;

    localparam int FRAME_SHIFT = 12;
    localparam int OFFSET_LSB  = 47;
    localparam logic [63:0] HIGH_HALF_OFFSET = 64'hffff_8000_0000_0000;

    typedef struct packed {
        logic clear;
        logic load;
        logic check;
        logic scan_read;
        logic scan_eval;
        logic bit_step;
        logic fill_read;
        logic fill_write;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        op_t  op;
        logic count_zero;
        logic count_big;
        logic range_bad;
        logic hit;
        logic miss;
        logic go_bits;
        logic go_word;
        logic fill_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- rtl/bpfa_ctrl.sv -----
// Controller state machine of the bitmap page frame allocator.
module bpfa_ctrl import bpfa_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                unique case (stat.op)
                    OP_ALLOC_ONE: begin
                        state_next = S_SCAN_RD;
                    end
                    OP_ALLOC_RUN: begin
                        state_next = (stat.count_zero || stat.count_big) ? S_DONE : S_SCAN_RD;
                    end
                    OP_FREE_RUN, OP_LOCK_RUN: begin
                        state_next = (stat.count_zero || stat.range_bad) ? S_DONE : S_FILL_RD;
                    end
                endcase
            end
            S_SCAN_RD: begin
                cmd.scan_read = 1'b1;
                state_next    = S_SCAN_EVAL;
            end
            S_SCAN_EVAL: begin
                cmd.scan_eval = 1'b1;
                priority if (stat.hit) begin
                    state_next = S_FILL_RD;
                end else if (stat.miss) begin
                    state_next = S_DONE;
                end else if (stat.go_bits) begin
                    state_next = S_BIT;
                end
            end
            S_BIT: begin
                cmd.bit_step = 1'b1;
                priority if (stat.hit) begin
                    state_next = S_FILL_RD;
                end else if (stat.miss) begin
                    state_next = S_DONE;
                end else if (stat.go_word) begin
                    state_next = S_SCAN_RD;
                end
            end
            S_FILL_RD: begin
                cmd.fill_read = 1'b1;
                state_next    = S_FILL_WR;
            end
            S_FILL_WR: begin
                cmd.fill_write = 1'b1;
                state_next     = stat.fill_last ? S_DONE : S_FILL_RD;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/bpfa_dpath.sv -----
// Datapath of the bitmap page frame allocator: frame map memory, scan and fill logic.
module bpfa_dpath import bpfa_pkg::*; #(
    parameter int FRAMES = 4096
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  dp_cmd_t       cmd,
    output dp_stat_t      stat,
    input  logic [1:0]    s_opcode,
    input  logic [63:0]   s_page_address,
    input  logic [12:0]   s_frame_count,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    input  logic          m_ready,
    output logic          m_valid,
    output logic [1:0]    m_status,
    output logic [63:0]   m_result_address,
    output logic [31:0]   m_reserved_total
);

    localparam int WORDS = (FRAMES + 63) / 64;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FXW   = WAW + 6;
    localparam int TAIL  = FRAMES % 64;
    localparam logic [63:0] PAD_MASK = (TAIL == 0) ? 64'd0 : ~((64'd1 << TAIL) - 64'd1);
    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
    localparam logic [52:0] FRAMES_53 = 53'(FRAMES);

    function automatic logic [5:0] lowest_zero(input logic [63:0] w);
        logic [5:0] pos;
        pos = '0;
        for (int j = 63; j >= 0; j--) begin
            if (!w[j]) begin
                pos = 6'(j);
            end
        end
        return pos;
    endfunction

    logic [63:0]    mem [WORDS];
    logic [63:0]    rdata_reg;

    op_t            op_reg;
    logic [63:0]    addr_reg;
    logic [12:0]    count_reg;
    logic           hh_reg;
    status_t        code_reg;
    logic [WAW-1:0] word_idx_reg;
    logic [5:0]     bit_idx_reg;
    logic [12:0]    run_reg;
    logic [63:0]    word_reg;
    logic [FXW-1:0] fill_first_reg;
    logic [FXW-1:0] fill_last_reg;
    logic           fill_set_reg;
    logic [WAW-1:0] fill_word_reg;
    logic [31:0]    reserved_reg;
    logic [WAW-1:0] clr_idx_reg;
    logic           m_valid_reg;
    status_t        m_status_reg;
    logic [63:0]    m_result_address_reg;
    logic [31:0]    m_reserved_total_reg;

    logic [16:0]    sub_hi;
    logic [63:0]    phys_addr;
    logic [52:0]    run_end;
    logic           count_zero;
    logic           count_big;
    logic           range_bad;
    logic [FXW-1:0] chk_first;
    logic [FXW-1:0] chk_last;
    status_t        chk_code;
    logic [32:0]    reserved_sum;
    logic [31:0]    reserved_sat;

    logic [63:0]    masked;
    logic           all_used;
    logic           all_free;
    logic [13:0]    run_wide;
    logic           fits;
    logic [5:0]     tail_j;
    logic           is_last;
    logic           eval_hit;
    logic           eval_bits;
    logic           eval_miss;
    logic [FXW-1:0] eval_end;

    logic           bit_used;
    logic [12:0]    run_step;
    logic           bit_hit;
    logic           bit_word_end;
    logic           bit_miss;
    logic [FXW-1:0] bit_end;

    logic           any_hit;
    logic [FXW-1:0] hit_end;
    logic [FXW-1:0] hit_first;
    logic           is_alloc;

    logic [5:0]     fill_lo;
    logic [5:0]     fill_hi;
    logic [63:0]    fill_mask;
    logic [63:0]    fill_data;

    logic           mem_we;
    logic [WAW-1:0] mem_waddr;
    logic [63:0]    mem_wdata;
    logic [WAW-1:0] mem_raddr;
    logic [63:0]    result_addr;

    // Range check of run operations; only the top bits of the high-half offset are non-zero.
    always_comb begin
        sub_hi     = (hh_reg && op_reg == OP_FREE_RUN) ? HIGH_HALF_OFFSET[63:OFFSET_LSB] : 17'd0;
        phys_addr  = {addr_reg[63:OFFSET_LSB] - sub_hi, addr_reg[OFFSET_LSB-1:0]};
        run_end    = {1'b0, phys_addr[63:FRAME_SHIFT]} + 53'(count_reg);
        count_zero = (count_reg == 13'd0);
        count_big  = ({19'd0, count_reg} > 32'(FRAMES));
        range_bad  = (run_end > FRAMES_53);
        chk_first  = phys_addr[FXW+FRAME_SHIFT-1:FRAME_SHIFT];
        chk_last   = chk_first + FXW'(count_reg) - FXW'(1);
        unique case (op_reg)
            OP_ALLOC_ONE: chk_code = ST_NO_SPACE;
            OP_ALLOC_RUN: chk_code = count_zero ? ST_ZERO_COUNT :
                                     (count_big ? ST_RANGE : ST_NO_SPACE);
            OP_FREE_RUN, OP_LOCK_RUN: chk_code = count_zero ? ST_ZERO_COUNT :
                                                 (range_bad ? ST_RANGE : ST_OK);
        endcase
        reserved_sum = {1'b0, reserved_reg} + 33'(count_reg);
        reserved_sat = reserved_sum[32] ? 32'hffff_ffff : reserved_sum[31:0];
    end

    // Word-wide scan step and bit-serial walk through a partly used word.
    always_comb begin
        is_last   = (word_idx_reg == LAST_WORD);
        masked    = rdata_reg | (is_last ? PAD_MASK : 64'd0);
        all_used  = &masked;
        all_free  = ~|masked;
        run_wide  = {1'b0, run_reg} + 14'd64;
        fits      = (run_wide >= {1'b0, count_reg});
        tail_j    = 6'(count_reg - run_reg - 13'd1);
        eval_hit  = (op_reg == OP_ALLOC_ONE) ? !all_used : (all_free && fits);
        eval_bits = (op_reg == OP_ALLOC_RUN) && !all_used && !all_free;
        eval_miss = is_last && !eval_hit && !eval_bits;
        eval_end  = {word_idx_reg,
                     (op_reg == OP_ALLOC_ONE) ? lowest_zero(masked) : tail_j};

        bit_used     = word_reg[bit_idx_reg];
        run_step     = bit_used ? 13'd0 : run_reg + 13'd1;
        bit_hit      = (run_step == count_reg);
        bit_word_end = (bit_idx_reg == 6'd63);
        bit_miss     = bit_word_end && is_last && !bit_hit;
        bit_end      = {word_idx_reg, bit_idx_reg};

        any_hit   = cmd.bit_step ? bit_hit : eval_hit;
        hit_end   = cmd.bit_step ? bit_end : eval_end;
        hit_first = (op_reg == OP_ALLOC_ONE) ? hit_end :
                    hit_end - FXW'(count_reg) + FXW'(1);
        is_alloc  = (op_reg == OP_ALLOC_ONE) || (op_reg == OP_ALLOC_RUN);
    end

    // Read-modify-write mask for one word of a run.
    always_comb begin
        fill_lo   = (fill_word_reg == fill_first_reg[FXW-1:6]) ? fill_first_reg[5:0] : 6'd0;
        fill_hi   = (fill_word_reg == fill_last_reg[FXW-1:6]) ? fill_last_reg[5:0] : 6'd63;
        fill_mask = ({64{1'b1}} << fill_lo) & ({64{1'b1}} >> (6'd63 - fill_hi));
        fill_data = fill_set_reg ? (rdata_reg | fill_mask) : (rdata_reg & ~fill_mask);
    end

    always_comb begin
        mem_we    = cmd.clear || cmd.fill_write;
        mem_waddr = cmd.clear ? clr_idx_reg : fill_word_reg;
        mem_wdata = cmd.clear ? 64'd0 : fill_data;
        priority if (cmd.fill_read) begin
            mem_raddr = fill_word_reg;
        end else if (cmd.scan_eval && !is_last) begin
            mem_raddr = word_idx_reg + WAW'(1);
        end else begin
            mem_raddr = word_idx_reg;
        end
    end

    always_comb begin
        stat.clear_done = (clr_idx_reg == LAST_WORD);
        stat.op         = op_reg;
        stat.count_zero = count_zero;
        stat.count_big  = count_big;
        stat.range_bad  = range_bad;
        stat.hit        = any_hit;
        stat.miss       = cmd.bit_step ? bit_miss : eval_miss;
        stat.go_bits    = eval_bits;
        stat.go_word    = bit_word_end && !is_last;
        stat.fill_last  = (fill_word_reg == fill_last_reg[FXW-1:6]);
        stat.out_free   = !m_valid_reg || m_ready;
    end

    assign result_addr = ({{(64 - FXW){1'b0}}, fill_first_reg} << FRAME_SHIFT)
                         + (hh_reg ? HIGH_HALF_OFFSET : 64'd0);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hh_reg       <= 1'b0;
            reserved_reg <= '0;
            clr_idx_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                hh_reg <= cfg_wdata;
            end
            if (cmd.clear) begin
                clr_idx_reg <= clr_idx_reg + WAW'(1);
            end
            if (cmd.check && op_reg == OP_LOCK_RUN && !count_zero && !range_bad) begin
                reserved_reg <= reserved_sat;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= op_t'(s_opcode);
            addr_reg  <= s_page_address;
            count_reg <= s_frame_count;
        end
        if (cmd.check) begin
            code_reg       <= chk_code;
            word_idx_reg   <= '0;
            run_reg        <= '0;
            fill_first_reg <= chk_first;
            fill_last_reg  <= chk_last;
            fill_set_reg   <= (op_reg == OP_LOCK_RUN);
            fill_word_reg  <= chk_first[FXW-1:6];
        end
        if ((cmd.scan_eval || cmd.bit_step) && any_hit) begin
            code_reg       <= ST_OK;
            fill_first_reg <= hit_first;
            fill_last_reg  <= hit_end;
            fill_set_reg   <= 1'b1;
            fill_word_reg  <= hit_first[FXW-1:6];
        end else if (cmd.scan_eval) begin
            if (eval_bits) begin
                word_reg    <= masked;
                bit_idx_reg <= '0;
            end else if (!is_last) begin
                word_idx_reg <= word_idx_reg + WAW'(1);
                run_reg      <= all_used ? 13'd0 : run_wide[12:0];
            end
        end else if (cmd.bit_step) begin
            run_reg     <= run_step;
            bit_idx_reg <= bit_idx_reg + 6'd1;
            if (bit_word_end && !is_last) begin
                word_idx_reg <= word_idx_reg + WAW'(1);
            end
        end
        if (cmd.fill_write) begin
            fill_word_reg <= fill_word_reg + WAW'(1);
        end
        if (cmd.finish) begin
            m_status_reg         <= code_reg;
            m_result_address_reg <= (code_reg == ST_OK && is_alloc) ? result_addr : 64'd0;
            m_reserved_total_reg <= reserved_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_result_address = m_result_address_reg;
    assign m_reserved_total = m_reserved_total_reg;

endmodule

// ----- rtl/bitmap_page_frame_allocator.sv -----
// Top level of the bitmap page frame allocator.
//
// A request enters on the s_ channel (s_valid/s_ready) and carries an opcode, a page
// address and a frame count. Each request gives exactly one result on the m_ channel
// (m_valid/m_ready): a status, the allocated address and the reserved frame tally.
// The high-half mode bit is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle; the block itself does not enforce it. One request is
// handled at a time; the frame map is a memory of 64-bit words with one read and one
// write port, and that port sets the timing. Allocate one reads the map a word at a
// time until it finds a free frame. Allocate run scans whole words the same way and
// walks a partly used word one frame per cycle. Free run and lock run read and write
// back each map word they span, as do both allocations for the frames they take.
// After reset the map is cleared one word per cycle, and s_ready stays low until
// that pass ends. The result waits in an output register; a new request may be
// accepted while it is not yet taken, but the block holds its next result until the
// receiver takes it.
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
    parameter int FRAMES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [63:0] s_page_address,
    input  logic [12:0] s_frame_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_result_address,
    output logic [31:0] m_reserved_total,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bpfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bpfa_dpath #(
        .FRAMES (FRAMES)
    ) u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_opcode         (s_opcode),
        .s_page_address   (s_page_address),
        .s_frame_count    (s_frame_count),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_status         (m_status),
        .m_result_address (m_result_address),
        .m_reserved_total (m_reserved_total)
    );

`ifndef SYNTHESIS
    a_one_request_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("The block was ready again straight after accepting a request.");

    a_failed_result_has_no_address: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_result_address == 64'd0))
        else $error("A failed request returned a non-zero address.");

    a_address_frame_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_address[11:0] == 12'd0))
        else $error("A returned address is not frame aligned.");
`endif

endmodule
